### rtl/brbc_pkg.sv
// Shared types and codes for the chunked byte ring buffer.
`timescale 1ns / 1ps

package brbc_pkg;

    localparam int SIZE_W = 13;
    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_PEEK  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } brbc_op_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAIL    = 2'd1,
        ST_TOOLONG = 2'd2,
        ST_UNUSED  = 2'd3
    } brbc_status_e;

    typedef struct packed {
        brbc_op_e            operation;
        logic [SIZE_W-1:0]   request_size;
        logic [BYTE_W-1:0]   data_in;
        logic                chunk_start;
    } brbc_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic                has_data;
        brbc_status_e        status;
        logic                last;
        logic [SIZE_W-1:0]   fill_level;
        logic [SIZE_W-1:0]   free_space;
    } brbc_rsp_t;

    // Everything of a result except the byte, which joins from the store.
    typedef struct packed {
        logic                has_data;
        brbc_status_e        status;
        logic                last;
        logic [SIZE_W-1:0]   fill_level;
        logic [SIZE_W-1:0]   free_space;
    } brbc_meta_t;

endpackage

### rtl/brbc_store.sv
// Single-port byte store with a registered read.
`timescale 1ns / 1ps

module brbc_store
    import brbc_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int PW    = 12
)
(
    input  logic              clk,
    input  logic [PW-1:0]     addr,
    input  logic              we,
    input  logic [BYTE_W-1:0] wdata,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] store_mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[addr] <= wdata;
        end
        rdata_reg <= store_mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/brbc_ctrl.sv
// Pointer, count and chunk bookkeeping; sequences byte reads from the store.
`timescale 1ns / 1ps

module brbc_ctrl
    import brbc_pkg::*;
#(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64,
    parameter int PW       = 12,
    parameter int CW       = 13,
    parameter int LW       = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  brbc_req_t         req,
    input  logic              room,
    output logic [PW-1:0]     mem_addr,
    output logic              mem_we,
    output logic [BYTE_W-1:0] mem_wdata,
    output logic              issue,
    output brbc_meta_t        meta
);

    localparam int W = (CW > SIZE_W) ? CW : SIZE_W;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     rp_reg, rp_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SIZE_W-1:0] chunk_left_reg, chunk_left_next;
    logic              chunk_ok_reg, chunk_ok_next;
    logic [PW-1:0]     addr_reg, addr_next;
    logic [LW-1:0]     left_reg, left_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic [SIZE_W-1:0] free_reg, free_next;

    logic              accept;
    logic [W-1:0]      size_w;
    logic [W-1:0]      space_w;
    logic [W-1:0]      fill_w;
    logic [W-1:0]      free_w;
    logic [SIZE_W-1:0] left_v;
    logic              ok_v;
    logic [PW:0]       rp_sum;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PW'(1);
        end
        return r;
    endfunction

    assign req_stall = (state_reg == S_STREAM) || !room;
    assign accept    = req_valid && !req_stall;
    assign size_w    = W'(req.request_size);
    assign space_w   = W'(DEPTH) - W'(cnt_reg);
    assign rp_sum    = {1'b0, rp_reg} + (PW+1)'(req.request_size);

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        chunk_left_next = chunk_left_reg;
        chunk_ok_next   = chunk_ok_reg;
        addr_next       = addr_reg;
        left_next       = left_reg;
        mem_addr        = addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = req.data_in;
        issue           = 1'b0;
        meta            = '0;
        left_v          = chunk_left_reg;
        ok_v            = chunk_ok_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.operation)
                        OP_WRITE:
                        begin
                            issue = 1'b1;
                            if (req.chunk_start && (req.request_size == '0))
                            begin
                                chunk_left_next = '0;
                                chunk_ok_next   = 1'b0;
                                meta.status     = ST_FAIL;
                                meta.last       = 1'b1;
                            end
                            else if (!req.chunk_start && (chunk_left_reg == '0))
                            begin
                                meta.status = ST_FAIL;
                                meta.last   = 1'b1;
                            end
                            else
                            begin
                                if (req.chunk_start)
                                begin
                                    left_v = req.request_size;
                                    ok_v   = (size_w <= space_w);
                                end
                                if (ok_v && (cnt_reg < CW'(DEPTH)))
                                begin
                                    mem_we   = 1'b1;
                                    mem_addr = wp_reg;
                                    wp_next  = ptr_inc(wp_reg);
                                    cnt_next = cnt_reg + CW'(1);
                                end
                                left_v = left_v - SIZE_W'(1);
                                if (left_v == '0)
                                begin
                                    meta.last   = 1'b1;
                                    meta.status = ok_v ? ST_OK : ST_FAIL;
                                    ok_v        = 1'b0;
                                end
                                chunk_left_next = left_v;
                                chunk_ok_next   = ok_v;
                            end
                        end
                        OP_PEEK, OP_READ:
                        begin
                            issue     = 1'b1;
                            meta.last = 1'b1;
                            if (req.request_size > SIZE_W'(MAX_READ))
                            begin
                                meta.status = ST_TOOLONG;
                            end
                            else if (size_w > W'(cnt_reg))
                            begin
                                meta.status = ST_FAIL;
                            end
                            else if (req.request_size != '0)
                            begin
                                // first byte goes out now, the rest stream
                                meta.has_data = 1'b1;
                                mem_addr      = rp_reg;
                                if (req.operation == OP_READ)
                                begin
                                    cnt_next = cnt_reg - CW'(req.request_size);
                                    rp_next  = (rp_sum >= (PW+1)'(DEPTH))
                                             ? PW'(rp_sum - (PW+1)'(DEPTH))
                                             : PW'(rp_sum);
                                end
                                if (req.request_size != SIZE_W'(1))
                                begin
                                    meta.last  = 1'b0;
                                    state_next = S_STREAM;
                                    addr_next  = ptr_inc(rp_reg);
                                    left_next  = LW'(req.request_size - SIZE_W'(1));
                                end
                            end
                        end
                        default:
                        begin
                            issue = 1'b0;
                        end
                    endcase
                end
                fill_w          = W'(cnt_next);
                free_w          = W'(DEPTH) - fill_w;
                meta.fill_level = fill_w[SIZE_W-1:0];
                meta.free_space = free_w[SIZE_W-1:0];
            end
            S_STREAM:
            begin
                fill_w          = W'(cnt_reg);
                free_w          = W'(DEPTH) - fill_w;
                meta.fill_level = fill_reg;
                meta.free_space = free_reg;
                if (room)
                begin
                    issue         = 1'b1;
                    meta.has_data = 1'b1;
                    meta.last     = (left_reg == LW'(1));
                    addr_next     = ptr_inc(addr_reg);
                    left_next     = left_reg - LW'(1);
                    if (left_reg == LW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                fill_w     = '0;
                free_w     = '0;
                state_next = S_IDLE;
            end
        endcase
    end

    assign fill_next = (state_reg == S_IDLE) ? meta.fill_level : fill_reg;
    assign free_next = (state_reg == S_IDLE) ? meta.free_space : free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            cnt_reg        <= '0;
            chunk_left_reg <= '0;
            chunk_ok_reg   <= 1'b0;
            addr_reg       <= '0;
            left_reg       <= '0;
            fill_reg       <= '0;
            free_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
            chunk_left_reg <= chunk_left_next;
            chunk_ok_reg   <= chunk_ok_next;
            addr_reg       <= addr_next;
            left_reg       <= left_next;
            fill_reg       <= fill_next;
            free_reg       <= free_next;
        end
    end

endmodule

### rtl/byte_ring_buffer_chunked_top.sv
// Top level of the chunked byte ring buffer: store, control and result queue.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid, req_stall | brbc_req_t: op, size, byte, start
//  rsp     | out       | rsp_valid, rsp_stall | brbc_rsp_t: byte, flags, levels
//
//  A write byte, a rejected request and an unused operation need no streaming.
//  A peek or read of N bytes makes one store read per cycle while the queue has
//  room: the first byte is read at the edge that takes the request, and req_stall
//  stays high while the remaining N - 1 bytes stream. Each result is offered on
//  rsp from the edge after the one that reads its byte.
//  Reset (rst_n low, asynchronous) empties the ring; the store is not cleared.
//  rsp_stall backs up through a two-entry result queue; req_stall rises once
//  the queue and the byte in flight would leave no room.

module byte_ring_buffer_chunked_top
    import brbc_pkg::*;
#(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  brbc_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output brbc_rsp_t rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(MAX_READ + 1);

    logic [PW-1:0]     mem_addr;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    logic              issue;
    brbc_meta_t        meta;
    logic              room;
    logic              pop;
    logic              push;
    logic              tail;
    brbc_rsp_t         push_rsp;

    // Result in flight: registered alongside the store read that fetches its byte.
    logic              s1_valid_reg, s1_valid_next;
    brbc_meta_t        s1_meta_reg;

    // Two-entry result queue.
    brbc_rsp_t         q_reg [2];
    logic              q_head_reg, q_head_next;
    logic [1:0]        q_cnt_reg, q_cnt_next;

    brbc_store #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_store (
        .clk   (clk),
        .addr  (mem_addr),
        .we    (mem_we),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    brbc_ctrl #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ),
        .PW       (PW),
        .CW       (CW),
        .LW       (LW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .room      (room),
        .mem_addr  (mem_addr),
        .mem_we    (mem_we),
        .mem_wdata (mem_wdata),
        .issue     (issue),
        .meta      (meta)
    );

    assign rsp_valid = (q_cnt_reg != 2'd0);
    assign rsp       = q_reg[q_head_reg];
    assign pop       = rsp_valid && !rsp_stall;
    assign push      = s1_valid_reg;
    assign tail      = q_head_reg ^ q_cnt_reg[0];

    // Issue only if the queue will still hold a free entry when this result lands.
    assign room = ((3'(q_cnt_reg) + 3'(s1_valid_reg) - 3'(pop)) <= 3'd1);

    // Join the byte from the store; results without a byte carry zero.
    always_comb
    begin
        push_rsp.data_out   = s1_meta_reg.has_data ? mem_rdata : '0;
        push_rsp.has_data   = s1_meta_reg.has_data;
        push_rsp.status     = s1_meta_reg.status;
        push_rsp.last       = s1_meta_reg.last;
        push_rsp.fill_level = s1_meta_reg.fill_level;
        push_rsp.free_space = s1_meta_reg.free_space;
    end

    assign s1_valid_next = issue;
    assign q_head_next   = q_head_reg ^ pop;
    assign q_cnt_next    = q_cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_head_reg   <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            q_head_reg   <= q_head_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    // Payload: hold unless a new result is captured.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_meta_reg <= meta;
        end
        if (push)
        begin
            q_reg[tail] <= push_rsp;
        end
    end

`ifndef SYNTHESIS
    // A result in flight never lands on a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (q_cnt_reg != 2'd2))
        else $error("result pushed into full queue");

    // Only successful peeks and reads deliver bytes.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.has_data) |-> (rsp.status == ST_OK))
        else $error("byte delivered with failing status");

    // Fill level and free space always add up to the ring size.
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.fill_level + rsp.free_space) == SIZE_W'(DEPTH)))
        else $error("fill level and free space disagree");

    // Nothing is accepted while the queue offers no room.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> req_stall)
        else $error("request taken without queue room");
`endif

endmodule

### tb/byte_ring_buffer_chunked_top_tb.sv
// Self-checking testbench for the chunked byte ring buffer: directed and random requests.
`timescale 1ns / 1ps

module byte_ring_buffer_chunked_top_tb;
    import brbc_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int RING_PW     = $clog2(RING_DEPTH);
    localparam int FETCH_MAX   = 64;
    localparam int RANDOM_REQS = 230;
    // Requests at the tail of the random part that go through with no idling at all.
    localparam int CALM_TAIL   = 40;
    // Worst case is roughly 20k results each waiting out the longest result stall;
    // allow several times that.
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    brbc_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    brbc_rsp_t rsp;

    byte_ring_buffer_chunked_top #(
        .DEPTH    (RING_DEPTH),
        .MAX_READ (FETCH_MAX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------
    // Ring predictor: its own copy of the store, both pointers, the fill
    // count and the state of the chunk being written.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    int                ring_rd    = 0;
    int                ring_wr    = 0;
    int                ring_count = 0;
    int                chunk_left = 0;
    bit                chunk_ok   = 1'b0;

    // Results the ring owes, oldest first, and requests still to be sent.
    brbc_rsp_t due_rsp[$];
    brbc_req_t req_backlog[$];

    bit req_fire    = 1'b0;
    bit no_idle     = 1'b0;
    int fail_count  = 0;
    int cycle_count = 0;
    int req_total   = 0;

    // Queue one expected result; levels are those after the whole request.
    function automatic void post_result(logic [BYTE_W-1:0] value, logic carries,
                                        brbc_status_e st, logic fin);
        brbc_rsp_t r;
        r.data_out   = value;
        r.has_data   = carries;
        r.status     = st;
        r.last       = fin;
        r.fill_level = SIZE_W'(ring_count);
        r.free_space = SIZE_W'(RING_DEPTH - ring_count);
        due_rsp.push_back(r);
    endfunction

    // Advance the ring by one accepted request and queue what it owes.
    function automatic void ring_step(brbc_req_t r);
        int amount;
        int p;
        amount = int'(r.request_size);
        case (r.operation)
            OP_WRITE:
            begin
                if (r.chunk_start && amount == 0)
                begin
                    // Zero-length chunk: drop it and close any open one.
                    chunk_left = 0;
                    chunk_ok   = 1'b0;
                    post_result('0, 1'b0, ST_FAIL, 1'b1);
                end
                else if (!r.chunk_start && chunk_left == 0)
                begin
                    // Stray byte with no chunk open.
                    post_result('0, 1'b0, ST_FAIL, 1'b1);
                end
                else
                begin
                    // A new start abandons an open chunk; its stored bytes stay.
                    if (r.chunk_start)
                    begin
                        chunk_left = amount;
                        chunk_ok   = (amount <= RING_DEPTH - ring_count);
                    end
                    if (chunk_ok && ring_count < RING_DEPTH)
                    begin
                        ring_mem[RING_PW'(ring_wr)] = r.data_in;
                        ring_wr                     = (ring_wr + 1) % RING_DEPTH;
                        ring_count++;
                    end
                    chunk_left--;
                    if (chunk_left == 0)
                    begin
                        post_result('0, 1'b0, chunk_ok ? ST_OK : ST_FAIL, 1'b1);
                        chunk_ok = 1'b0;
                    end
                    else
                    begin
                        post_result('0, 1'b0, ST_OK, 1'b0);
                    end
                end
            end
            OP_PEEK, OP_READ:
            begin
                if (amount > FETCH_MAX)
                    post_result('0, 1'b0, ST_TOOLONG, 1'b1);
                else if (amount > ring_count)
                    post_result('0, 1'b0, ST_FAIL, 1'b1);
                else if (amount == 0)
                    post_result('0, 1'b0, ST_OK, 1'b1);
                else
                begin
                    p = ring_rd;
                    // A read frees its bytes before the levels are reported.
                    if (r.operation == OP_READ)
                        ring_count -= amount;
                    for (int i = 0; i < amount; i++)
                    begin
                        post_result(ring_mem[RING_PW'(p)], 1'b1, ST_OK, i == amount - 1);
                        p = (p + 1) % RING_DEPTH;
                    end
                    if (r.operation == OP_READ)
                        ring_rd = p;
                end
            end
            default:
            begin
                // Unused operation: nothing moves, nothing owed.
            end
        endcase
    endfunction

    // Compare one accepted result with the oldest one owed, field by field.
    task automatic check_rsp(brbc_rsp_t got);
        brbc_rsp_t want;
        if (due_rsp.size() == 0)
        begin
            $error("unexpected result: rsp = %h", got);
            fail_count++;
        end
        else
        begin
            want = due_rsp.pop_front();
            if (got.data_out !== want.data_out)
            begin
                $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
                fail_count++;
            end
            if (got.has_data !== want.has_data)
            begin
                $error("has_data: expected %0d, got %0d", want.has_data, got.has_data);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                fail_count++;
            end
            if (got.fill_level !== want.fill_level)
            begin
                $error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
                fail_count++;
            end
            if (got.free_space !== want.free_space)
            begin
                $error("free_space: expected %0d, got %0d", want.free_space, got.free_space);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the result
    // first, then predict from the request taken at the same edge; a request
    // never produces its result at the edge that takes it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        req_fire = rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
            begin
                if (rsp_valid && !rsp_stall)
                    check_rsp(rsp);
                if (req_fire)
                    ring_step(req);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: change inputs on the falling edge. Hold the payload
    // while stalled; once it is taken, either idle for a burst or load the
    // next request from the backlog. The idle rate changes from span to span
    // so that stretches with no idling occur as well.
    // ------------------------------------------------------------------
    int send_gap  = 0;
    int send_rate = 0;
    int send_span = 0;

    always @(negedge clk)
    begin
        if (send_span == 0)
        begin
            send_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            send_span = $urandom_range(20, 150);
        end
        else
        begin
            send_span--;
        end
        if (no_idle)
            send_gap = 0;
        if (rst_n && (!req_valid || req_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (req_backlog.size() == 0)
            begin
                req_valid <= 1'b0;
            end
            else if (!no_idle && $urandom_range(1, 100) <= send_rate)
            begin
                // This cycle is the first of the burst.
                send_gap = $urandom_range(1, 18) - 1;
                req_valid <= 1'b0;
            end
            else
            begin
                req       <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall: random bursts independent of rsp_valid, with calm spans
    // in between.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int recv_rate  = 0;
    int recv_span  = 0;

    always @(negedge clk)
    begin
        if (recv_span == 0)
        begin
            recv_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            recv_span = $urandom_range(20, 150);
        end
        else
        begin
            recv_span--;
        end
        if (stall_left > 0 && !no_idle)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (!no_idle && $urandom_range(1, 100) <= recv_rate)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            stall_left = 0;
            rsp_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic push_req(brbc_op_e op, int amount, logic [BYTE_W-1:0] value, logic first);
        brbc_req_t r;
        r.operation    = op;
        r.request_size = SIZE_W'(amount);
        r.data_in      = value;
        r.chunk_start  = first;
        req_backlog.push_back(r);
        if (op != OP_NONE)
            req_total++;
    endtask

    // Peek or read; the byte and start fields are ignored, so randomise them.
    task automatic ask(brbc_op_e op, int amount);
        push_req(op, amount, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Chunk declaring 'declared' bytes of which 'sent' are actually sent;
    // the size field is only meaningful on the first byte.
    task automatic push_chunk(int declared, int sent);
        for (int i = 0; i < sent; i++)
            push_req(OP_WRITE, (i == 0) ? declared : $urandom_range(0, RING_DEPTH),
                     BYTE_W'($urandom_range(0, 255)), i == 0);
    endtask

    // Pause the sender until the ring owes nothing and the request line is quiet.
    task automatic settle();
        while (req_backlog.size() != 0 || req_valid || due_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Random mix: mostly complete chunks and well-sized fetches, plus noise.
    task automatic random_phase();
        int goal;
        int roll;
        int avail;
        int n;
        brbc_op_e op;
        goal = req_total + RANDOM_REQS;
        while (req_total < goal)
        begin
            // Keep the fill estimate close to the ring by generating just in time.
            while (req_backlog.size() != 0)
                @(posedge clk);
            if (req_total >= goal - CALM_TAIL)
                no_idle = 1'b1;
            roll  = $urandom_range(0, 99);
            avail = ring_count;
            op    = ($urandom_range(0, 1) == 1) ? OP_READ : OP_PEEK;
            n     = (avail < FETCH_MAX) ? avail : FETCH_MAX;
            if (roll < 40)
            begin
                n = $urandom_range(1, 24);
                push_chunk(n, n);
            end
            else if (roll < 65)
            begin
                ask(op, (n == 0) ? $urandom_range(0, 2) : $urandom_range(1, n));
            end
            else if (roll < 70)
            begin
                ask(op, 0);
            end
            else if (roll < 75)
            begin
                // Ask for more than is stored, or FETCH_MAX if that is less.
                n = avail + $urandom_range(1, 4);
                ask(op, (n > FETCH_MAX) ? FETCH_MAX : n);
            end
            else if (roll < 80)
            begin
                ask(op, $urandom_range(FETCH_MAX + 1, RING_DEPTH));
            end
            else if (roll < 95)
            begin
                case ($urandom_range(0, 3))
                    0: push_req(OP_WRITE, $urandom_range(0, RING_DEPTH),
                                BYTE_W'($urandom_range(0, 255)), 1'b0);
                    1: push_req(OP_WRITE, 0, BYTE_W'($urandom_range(0, 255)), 1'b1);
                    2:
                    begin
                        // Left open; the next start abandons it.
                        n = $urandom_range(3, 30);
                        push_chunk(n, $urandom_range(1, n - 1));
                    end
                    default:
                    begin
                        // Longer than the free space (unless the ring is empty): rejected, left open.
                        n = RING_DEPTH - avail + $urandom_range(1, 8);
                        push_chunk((n > RING_DEPTH) ? RING_DEPTH : n, $urandom_range(1, 4));
                    end
                endcase
            end
            else
            begin
                push_req(OP_NONE, $urandom_range(0, RING_DEPTH),
                         BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: the special cases on an empty ring first.
        push_req(OP_WRITE, 0, 8'hFF, 1'b0);      // stray byte, no chunk open
        push_req(OP_WRITE, 0, 8'h00, 1'b1);      // zero-length chunk
        ask(OP_PEEK, 0);                          // empty request
        ask(OP_READ, 1);                          // not enough data
        ask(OP_PEEK, FETCH_MAX + 1);              // just too long
        ask(OP_PEEK, RING_DEPTH - 1);             // all low size bits set
        ask(OP_READ, RING_DEPTH);                 // top size bit set
        push_req(OP_WRITE, 3, 8'h00, 1'b1);
        push_req(OP_WRITE, 0, 8'hFF, 1'b0);
        push_req(OP_WRITE, 0, 8'h5A, 1'b0);
        ask(OP_PEEK, 3);
        ask(OP_READ, 2);
        ask(OP_READ, FETCH_MAX);                  // at the limit but more than stored
        // Chunk longer than the free space, then abandoned by an accepted one.
        push_req(OP_WRITE, RING_DEPTH, 8'h81, 1'b1);
        push_req(OP_WRITE, 0, 8'h7E, 1'b0);
        push_req(OP_WRITE, 2, 8'hA5, 1'b1);
        push_req(OP_WRITE, 0, 8'h3C, 1'b0);
        ask(OP_READ, 3);
        push_req(OP_NONE, 5, 8'h12, 1'b1);        // unused operation
        // Accepted chunk abandoned part-way; its bytes must stay stored.
        push_req(OP_WRITE, 5, 8'h11, 1'b1);
        push_req(OP_WRITE, 0, 8'h22, 1'b0);
        push_req(OP_WRITE, 1, 8'h33, 1'b1);
        ask(OP_READ, 3);

        // Hold the sender until the ring has answered everything so far.
        settle();

        random_phase();

        // Wait for every owed result, then a little longer for strays.
        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (due_rsp.size() != 0)
        begin
            $error("%0d results never arrived", due_rsp.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
